// ===== src/lc3_pkg.sv =====
package lc3_pkg;

  localparam int MemWords = 65536;
  localparam int MemAw = $clog2(MemWords);
  localparam int QDepth = 2;

  localparam logic [15:0] PcReset = 16'h3000;

  // apb register index
  localparam logic [0:0] REG_START_PC = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_EXEC    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [3:0] OPC_BR   = 4'h0;
  localparam logic [3:0] OPC_ADD  = 4'h1;
  localparam logic [3:0] OPC_LD   = 4'h2;
  localparam logic [3:0] OPC_ST   = 4'h3;
  localparam logic [3:0] OPC_JSR  = 4'h4;
  localparam logic [3:0] OPC_AND  = 4'h5;
  localparam logic [3:0] OPC_LDR  = 4'h6;
  localparam logic [3:0] OPC_STR  = 4'h7;
  localparam logic [3:0] OPC_RTI  = 4'h8;
  localparam logic [3:0] OPC_NOT  = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_STI  = 4'hB;
  localparam logic [3:0] OPC_JMP  = 4'hC;
  localparam logic [3:0] OPC_RES  = 4'hD;
  localparam logic [3:0] OPC_LEA  = 4'hE;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  localparam logic [7:0] VEC_GETC = 8'h20;
  localparam logic [7:0] VEC_OUT  = 8'h21;
  localparam logic [7:0] VEC_PUTS = 8'h22;
  localparam logic [7:0] VEC_IN   = 8'h23;
  localparam logic [7:0] VEC_HALT = 8'h25;

  localparam logic [2:0] CC_N = 3'd4;
  localparam logic [2:0] CC_Z = 3'd2;
  localparam logic [2:0] CC_P = 3'd1;

  typedef struct packed {
    op_t         op;
    logic [15:0] address;
    logic [15:0] word;
    logic [7:0]  key_char;
  } item_t;

  typedef enum logic [2:0] {
    ST_DECODE,
    ST_MEM1,
    ST_MEM2,
    ST_MEM3,
    ST_OUT
  } state_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) return CC_Z;
    else if (v[15]) return CC_N;
    else return CC_P;
  endfunction

endpackage

// ===== src/lc3_ram.sv =====
module lc3_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/lc3_queue.sv =====
module lc3_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lc3_pkg::item_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output lc3_pkg::item_t  out_item
);
  localparam int Aw = $clog2(lc3_pkg::QDepth);

  lc3_pkg::item_t slots [lc3_pkg::QDepth];
  logic [Aw-1:0] wptr, rptr;
  logic [Aw:0]   count;
  logic push, pop;

  assign in_ready  = count != (Aw+1)'(lc3_pkg::QDepth);
  assign out_valid = count != '0;
  assign out_item  = slots[rptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_item;
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end
endmodule

// ===== src/lc3_exec.sv =====
module lc3_exec (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    start_pc,
  input  logic           in_valid,
  output logic           in_ready,
  input  lc3_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_data
);
  localparam int Aw = lc3_pkg::MemAw;

  lc3_pkg::state_t state, state_next;
  lc3_pkg::item_t  cur;
  logic [15:0] regs [8];
  logic [15:0] pc;
  logic [2:0]  cc;
  logic        halt;
  logic [15:0] ptr;

  // result register
  logic        res_valid;
  logic        res_cv;
  logic [7:0]  res_co;
  logic        res_err;

  logic          we;
  logic [Aw-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  lc3_ram #(.Width(16), .Depth(lc3_pkg::MemWords)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic [15:0] w;
  logic [3:0]  opc;
  logic [2:0]  dr, sr1;
  logic [15:0] off9, off6, off11, imm5, pc1, a, b, pcoff, basoff;
  logic        res_free;

  assign w     = cur.word;
  assign opc   = w[15:12];
  assign dr    = w[11:9];
  assign sr1   = w[8:6];
  assign off9  = {{7{w[8]}}, w[8:0]};
  assign off6  = {{10{w[5]}}, w[5:0]};
  assign off11 = {{5{w[10]}}, w[10:0]};
  assign imm5  = {{11{w[4]}}, w[4:0]};
  assign pc1   = pc + 16'd1;
  assign a     = regs[sr1];
  assign b     = w[5] ? imm5 : regs[w[2:0]];
  assign pcoff = pc1 + off9;
  assign basoff = a + off6;
  assign res_free = !res_valid || out_ready;

  // decode takes an item when the result slot can be refilled
  assign in_ready = (state == lc3_pkg::ST_DECODE) && res_free;

  logic needs_mem;
  always_comb begin
    needs_mem = 1'b0;
    if (in_item.op == lc3_pkg::OP_EXEC && !halt) begin
      unique case (in_item.word[15:12]) inside
        lc3_pkg::OPC_LD, lc3_pkg::OPC_LDI, lc3_pkg::OPC_LDR, lc3_pkg::OPC_STI:
          needs_mem = 1'b1;
        default: needs_mem = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lc3_pkg::ST_DECODE: if (in_valid && in_ready && needs_mem)
        state_next = lc3_pkg::ST_MEM1;
      lc3_pkg::ST_MEM1:
        state_next = (opc == lc3_pkg::OPC_LDI || opc == lc3_pkg::OPC_STI) ?
                     lc3_pkg::ST_MEM2 : lc3_pkg::ST_MEM3;
      lc3_pkg::ST_MEM2: state_next = (opc == lc3_pkg::OPC_LDI) ?
                                     lc3_pkg::ST_MEM3 : lc3_pkg::ST_OUT;
      lc3_pkg::ST_MEM3: state_next = lc3_pkg::ST_OUT;
      lc3_pkg::ST_OUT:  if (res_free) state_next = lc3_pkg::ST_DECODE;
      default: state_next = lc3_pkg::ST_DECODE;
    endcase
  end

  // memory port control; reads are issued from decode using the incoming word
  logic [15:0] in_w, in_pc1, in_pcoff, in_bas;
  assign in_w     = in_item.word;
  assign in_pc1   = pc + 16'd1;
  assign in_pcoff = in_pc1 + {{7{in_w[8]}}, in_w[8:0]};
  assign in_bas   = regs[in_w[8:6]] + {{10{in_w[5]}}, in_w[5:0]};

  // decode results for the incoming word
  logic [15:0] alu_a, alu_b, alu_v, exec_pc;
  logic        res_cv_next, res_err_next;
  logic [7:0]  res_co_next;
  assign alu_a = regs[in_w[8:6]];
  assign alu_b = in_w[5] ? {{11{in_w[4]}}, in_w[4:0]} : regs[in_w[2:0]];

  always_comb begin
    exec_pc = in_pc1;
    alu_v = in_pcoff;
    res_cv_next = 1'b0;
    res_co_next = '0;
    res_err_next = 1'b0;
    unique case (in_w[15:12]) inside
      lc3_pkg::OPC_ADD: alu_v = alu_a + alu_b;
      lc3_pkg::OPC_AND: alu_v = alu_a & alu_b;
      lc3_pkg::OPC_NOT: alu_v = ~alu_a;
      lc3_pkg::OPC_BR: if ((in_w[11:9] & cc) != 3'd0) exec_pc = in_pcoff;
      lc3_pkg::OPC_JMP: exec_pc = regs[in_w[8:6]];
      lc3_pkg::OPC_JSR:
        exec_pc = in_w[11] ? in_pc1 + {{5{in_w[10]}}, in_w[10:0]} : regs[in_w[8:6]];
      lc3_pkg::OPC_TRAP: begin
        if (in_w[7:0] == lc3_pkg::VEC_IN) begin
          res_cv_next = 1'b1;
          res_co_next = in_item.key_char;
        end else if (in_w[7:0] == lc3_pkg::VEC_OUT) begin
          res_cv_next = 1'b1;
          res_co_next = regs[0][7:0];
        end else if (in_w[7:0] != lc3_pkg::VEC_GETC && in_w[7:0] != lc3_pkg::VEC_HALT) begin
          res_err_next = 1'b1;
        end
      end
      lc3_pkg::OPC_RTI, lc3_pkg::OPC_RES: res_err_next = 1'b1;
      default: ;
    endcase
    if (in_item.op != lc3_pkg::OP_EXEC || halt) begin
      res_cv_next = 1'b0;
      res_co_next = '0;
      res_err_next = 1'b0;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = in_item.address[Aw-1:0];
    wdata = in_item.word;
    raddr = in_pcoff[Aw-1:0];
    unique case (state)
      lc3_pkg::ST_DECODE: begin
        if (in_w[15:12] == lc3_pkg::OPC_LDR) raddr = in_bas[Aw-1:0];
        if (in_valid && in_ready) begin
          if (in_item.op == lc3_pkg::OP_LOAD) begin
            we = 1'b1;
          end else if (in_item.op == lc3_pkg::OP_EXEC && !halt) begin
            if (in_w[15:12] == lc3_pkg::OPC_ST) begin
              we = 1'b1;
              waddr = in_pcoff[Aw-1:0];
              wdata = regs[in_w[11:9]];
            end else if (in_w[15:12] == lc3_pkg::OPC_STR) begin
              we = 1'b1;
              waddr = in_bas[Aw-1:0];
              wdata = regs[in_w[11:9]];
            end
          end
        end
      end
      lc3_pkg::ST_MEM1: raddr = rdata[Aw-1:0];
      lc3_pkg::ST_MEM2: begin
        raddr = ptr[Aw-1:0];
        if (opc == lc3_pkg::OPC_STI) begin
          we = 1'b1;
          waddr = ptr[Aw-1:0];
          wdata = regs[dr];
        end
      end
      default: raddr = ptr[Aw-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == lc3_pkg::ST_DECODE && in_valid && in_ready) cur <= in_item;
    if (state == lc3_pkg::ST_MEM1) ptr <= rdata;
    if (rst) begin
      state <= lc3_pkg::ST_DECODE;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      pc <= lc3_pkg::PcReset;
      cc <= lc3_pkg::CC_Z;
      halt <= 1'b0;
      res_valid <= 1'b0;
      res_cv <= 1'b0;
      res_co <= '0;
      res_err <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lc3_pkg::ST_DECODE && in_valid && in_ready) res_valid <= !needs_mem;
      else if (state == lc3_pkg::ST_OUT && res_free) res_valid <= 1'b1;
      else if (out_ready) res_valid <= 1'b0;
      if (state == lc3_pkg::ST_DECODE && in_valid && in_ready) begin
        res_cv <= res_cv_next;
        res_co <= res_co_next;
        res_err <= res_err_next;
        if (in_item.op == lc3_pkg::OP_RESTART) begin
          pc <= start_pc;
          halt <= 1'b0;
        end else if (in_item.op == lc3_pkg::OP_EXEC && !halt) begin
          pc <= exec_pc;
          unique case (in_w[15:12]) inside
            lc3_pkg::OPC_ADD, lc3_pkg::OPC_AND, lc3_pkg::OPC_NOT, lc3_pkg::OPC_LEA: begin
              regs[in_w[11:9]] <= alu_v;
              cc <= lc3_pkg::cc_of(alu_v);
            end
            lc3_pkg::OPC_JSR: regs[7] <= in_pc1;
            lc3_pkg::OPC_TRAP: begin
              if (in_w[7:0] == lc3_pkg::VEC_GETC || in_w[7:0] == lc3_pkg::VEC_IN) begin
                regs[7] <= in_pc1;
                regs[0] <= {8'd0, in_item.key_char};
                cc <= lc3_pkg::cc_of({8'd0, in_item.key_char});
              end else if (in_w[7:0] == lc3_pkg::VEC_OUT) begin
                regs[7] <= in_pc1;
              end else if (in_w[7:0] == lc3_pkg::VEC_HALT) begin
                regs[7] <= in_pc1;
                halt <= 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      // load data arrives registered, in the cycle after its read address
      if ((state == lc3_pkg::ST_MEM1 && opc != lc3_pkg::OPC_LDI && opc != lc3_pkg::OPC_STI)
          || (state == lc3_pkg::ST_MEM3 && opc == lc3_pkg::OPC_LDI)) begin
        regs[dr] <= rdata;
        cc <= lc3_pkg::cc_of(rdata);
      end
    end
  end

  assign out_valid = res_valid;
  assign out_data  = {2'd0, cc, pc, res_err, halt, res_co, res_cv};
  logic unused_ok;
  assign unused_ok = ^{a, b, pcoff, basoff, off11};
endmodule

// ===== src/lc3_instruction_executor.sv =====
// channel   | dir | bits                                       | request
// s_axis    | in  | operation, address, word, key_char (42)    | one item
// m_axis    | out | char_valid, char_out, halted, error,       | one result per item
//           |     | next_pc, cond_flags (30)                   |
// apb       | in  | start_pc at 0                              | register write
// most items need only the decode state in the executor; LD/LDR go on through MEM1, MEM3, OUT, STI through
// MEM1, MEM2, OUT and LDI through MEM1, MEM2, MEM3, OUT, as the word memory has a single read port (registered read)
// a two-entry queue lets the input side run ahead of the executor
// rst is synchronous: pc 0x3000, registers 0, flags Z, not halted
// memory contents are not cleared
module lc3_instruction_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // operation, address, word, key_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // char_valid, char_out, halted, error, next_pc, cond_flags
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] start_pc;
  lc3_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  assign pready = 1'b1;
  assign prdata = {16'd0, start_pc};
  always_ff @(posedge clk) begin
    if (rst) start_pc <= lc3_pkg::PcReset;
    else if (psel && penable && pwrite && paddr == lc3_pkg::REG_START_PC)
      start_pc <= pwdata[15:0];
  end

  assign in_item.op       = lc3_pkg::op_t'(s_axis_tdata[1:0]);
  assign in_item.address  = s_axis_tdata[17:2];
  assign in_item.word     = s_axis_tdata[33:18];
  assign in_item.key_char = s_axis_tdata[41:34];
  logic unused_ok;
  assign unused_ok = ^{s_axis_tdata[47:42], pwdata[31:16]};

  lc3_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  lc3_exec u_exec (
    .clk(clk), .rst(rst), .start_pc(start_pc),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );
endmodule
